>>> hw/rtl/adp_pkg.sv
// Shared types and constants of the antialiased dot painter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package adp_pkg;

    localparam int IMAGE_SIZE_DEF      = 2048;
    localparam int MAX_SUBSAMPLE_LEVEL = 7;
    localparam logic [15:0] ROOT_HALF_Q16 = 16'd46341;

    localparam int PIX_W  = 11;
    localparam int VAL_W  = 16;
    localparam int COV_W  = 17;
    localparam int TDATA_IN_W  = 40;
    localparam int TDATA_OUT_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    localparam int CRD_W = 27;   // sample offset from dot center, scaled by 512*(m+1)
    localparam int MAG_W = 28;   // shape-space magnitude
    localparam int RAD_W = 24;   // scaled radius / pen
    localparam int SQ_W  = 56;
    localparam int WGT_W = 13;
    localparam int SW_W  = 20;   // weight sums
    localparam int SV_W  = 38;   // weighted ink sum
    localparam int DVD_W = 40;
    localparam int QUO_W = 18;

    localparam logic [1:0] SHAPE_ROUND  = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_INK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_INK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SUBS     = 3'd7;

    typedef struct packed {
        logic signed [19:0] center_x;
        logic signed [19:0] center_y;
        logic [18:0]        radius;
        logic [18:0]        pen_half_width;
        logic [3:0]         mode_flags;
        logic signed [15:0] fill_ink;
        logic signed [15:0] draw_ink;
        logic [2:0]         subsample_level;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic radsq;
        logic rot;
        logic sq;
        logic acc;
        logic prep_val;
        logic div_start;
        logic div_sel_val;
        logic store_cov;
        logic store_val;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bypass;
        logic last_sample;
        logic div_done;
    } ctrl_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RADSQ,
        ST_ROT,
        ST_SQ,
        ST_ACC,
        ST_COV_START,
        ST_COV_WAIT,
        ST_VAL_PREP,
        ST_VAL_START,
        ST_VAL_WAIT,
        ST_FIN
    } state_t;

endpackage

>>> hw/rtl/adp_div.sv
// Radix-2 restoring divider, one dividend bit per cycle.
// Depends on adp_pkg for widths.
`timescale 1ns / 1ps
module adp_div import adp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [SW_W-1:0]  divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [SW_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SW_W:0]    trial;
    logic             ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            cnt_next  = CNT_W'(DVD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? SW_W'(trial - {1'b0, divisor}) : trial[SW_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/adp_datapath.sv
// Datapath: sample geometry, shape test, weight sums, divisions and result register.
// Depends on adp_pkg and adp_div.
`timescale 1ns / 1ps
module adp_datapath import adp_pkg::*; #(
    parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  ctrl_cmd_t               cmd,
    input  logic [PIX_W-1:0]        in_px,
    input  logic [PIX_W-1:0]        in_py,
    input  logic signed [VAL_W-1:0] in_old,
    output ctrl_sts_t               sts,
    output logic [VAL_W-1:0]        new_value,
    output logic [COV_W-1:0]        coverage
);

    // 1-D quadratic weight, scaled by n^2
    function automatic logic [6:0] weight1(input logic [2:0] a, input logic [3:0] n);
        logic [7:0] nn, aa2, dd2;
        logic [3:0] dd;
        nn  = {4'b0, n} * {4'b0, n};
        aa2 = {4'b0, a, 1'b0} * {5'b0, a};
        dd  = n - {1'b0, a};
        dd2 = {3'b0, dd, 1'b0} * {4'b0, dd};
        if ({a, 1'b0} < n) weight1 = 7'(nn - aa2);
        else weight1 = dd2[6:0];
    endfunction

    logic [PIX_W-1:0]        px_reg, py_reg;
    logic signed [VAL_W-1:0] old_reg;
    logic                    bypass_reg;
    logic [3:0]              n_reg;
    logic signed [4:0]       m_reg, dx_reg, dy_reg;
    logic signed [CRD_W-1:0] bx_reg, by_reg;
    logic [RAD_W-1:0]        r_reg, h_reg, irad_reg;
    logic [RAD_W:0]          orad_reg;
    logic [49:0]             orad2_reg;
    logic [47:0]             irad2_reg, h2_reg;
    logic [MAG_W-1:0]        ax_reg, ay_reg, ax2_reg, ay2_reg;
    logic [WGT_W-1:0]        w_reg, w2_reg;
    logic [SQ_W-1:0]         qx_reg, qy_reg;
    logic [SW_W-1:0]         sw_reg, swp_reg;
    logic signed [SV_W-1:0]  swpv_reg;
    logic signed [DVD_W-1:0] num_reg;
    logic [COV_W-1:0]        cov_reg;
    logic signed [VAL_W-1:0] newv_reg;
    logic [VAL_W-1:0]        out_new_reg;
    logic [COV_W-1:0]        out_cov_reg;

    logic       fill_on, draw_on;
    logic [1:0] shape;
    logic [2:0] m_sat;
    logic [3:0] n_c;

    assign fill_on = cfg.mode_flags[2];
    assign draw_on = cfg.mode_flags[3];
    assign shape   = cfg.mode_flags[1:0];
    assign m_sat   = (32'(cfg.subsample_level) > MAX_SUBSAMPLE_LEVEL) ?
                     3'(MAX_SUBSAMPLE_LEVEL) : cfg.subsample_level;
    assign n_c     = {1'b0, m_sat} + 4'd1;

    // item setup terms
    logic [15:0]             tx, ty;
    logic signed [CRD_W-1:0] cpx, cpy, twon;
    logic [RAD_W-1:0]        pen_eff;

    assign tx   = {4'b0, px_reg, 1'b1} * {12'b0, n_c};
    assign ty   = {4'b0, py_reg, 1'b1} * {12'b0, n_c};
    assign twon = {22'b0, n_c, 1'b0};
    assign cpx  = {{7{cfg.center_x[19]}}, cfg.center_x} * twon;
    assign cpy  = {{7{cfg.center_y[19]}}, cfg.center_y} * twon;
    assign pen_eff = draw_on ? {5'b0, cfg.pen_half_width} : '0;

    // per-sample geometry
    logic signed [CRD_W-1:0] offx, offy, sx, sy;
    logic signed [MAG_W-1:0] u, v, sxe, sye;
    logic [MAG_W-1:0]        au, av, asx, asy, ax_c, ay_c;
    logic [44:0]             pu, pv;
    logic [2:0]              adx, ady;

    assign offx = {{13{dx_reg[4]}}, dx_reg, 9'b0};
    assign offy = {{13{dy_reg[4]}}, dy_reg, 9'b0};
    assign sx   = bx_reg + offx;
    assign sy   = by_reg + offy;
    assign sxe  = {sx[CRD_W-1], sx};
    assign sye  = {sy[CRD_W-1], sy};
    assign u    = sxe + sye;
    assign v    = sye - sxe;
    assign au   = u[MAG_W-1] ? MAG_W'(-u) : MAG_W'(u);
    assign av   = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    assign asx  = sxe[MAG_W-1] ? MAG_W'(-sxe) : MAG_W'(sxe);
    assign asy  = sye[MAG_W-1] ? MAG_W'(-sye) : MAG_W'(sye);
    assign pu   = {17'b0, au} * {29'b0, ROOT_HALF_Q16} + 45'd32768;
    assign pv   = {17'b0, av} * {29'b0, ROOT_HALF_Q16} + 45'd32768;
    assign ax_c = shape[1] ? pu[43:16] : asx;
    assign ay_c = shape[1] ? pv[43:16] : asy;
    assign adx  = dx_reg[4] ? 3'(-dx_reg) : dx_reg[2:0];
    assign ady  = dy_reg[4] ? 3'(-dy_reg) : dy_reg[2:0];

    logic [MAG_W-1:0] selx, sely;
    assign selx = (shape == SHAPE_ROUND) ? ax_reg : ax_reg - {4'b0, r_reg};
    assign sely = (shape == SHAPE_ROUND) ? ay_reg : ay_reg - {4'b0, r_reg};

    // shape test
    logic [SQ_W:0]    d2;
    logic [MAG_W-1:0] irad_e, orad_e, r_e;
    logic             hit_fill, hit_draw;

    assign d2     = {1'b0, qx_reg} + {1'b0, qy_reg};
    assign irad_e = {4'b0, irad_reg};
    assign orad_e = {3'b0, orad_reg};
    assign r_e    = {4'b0, r_reg};

    always_comb begin
        hit_fill = 1'b0;
        hit_draw = 1'b0;
        if (shape == SHAPE_ROUND) begin
            if (d2 < {9'b0, irad2_reg}) hit_fill = 1'b1;
            else if (d2 < {7'b0, orad2_reg}) hit_draw = 1'b1;
        end else begin
            if (ax2_reg < irad_e && ay2_reg < irad_e) hit_fill = 1'b1;
            else if (ax2_reg > orad_e || ay2_reg > orad_e) hit_draw = 1'b0;
            else if (ax2_reg < r_e || ay2_reg < r_e) hit_draw = 1'b1;
            else if (d2 < {9'b0, h2_reg}) hit_draw = 1'b1;
        end
    end

    logic signed [SV_W-1:0] wink;
    logic                   take;
    logic signed [15:0]     ink;

    assign take = (hit_fill && fill_on) || (hit_draw && draw_on);
    assign ink  = (hit_fill && fill_on) ? cfg.fill_ink : cfg.draw_ink;
    assign wink = {{(SV_W-WGT_W){1'b0}}, w2_reg} * {{(SV_W-16){ink[15]}}, ink};

    logic last;
    assign last = (dx_reg == m_reg) && (dy_reg == m_reg);

    // final divisions
    logic [SW_W-1:0]         diff;
    logic signed [36:0]      prod;
    logic [DVD_W-1:0]        nmag, dvd_cov, dvd_val;
    logic                    div_done;
    logic [QUO_W-1:0]        quo;

    assign diff    = sw_reg - swp_reg;
    assign prod    = {17'b0, diff} * {{21{old_reg[15]}}, old_reg};
    assign nmag    = num_reg[DVD_W-1] ? DVD_W'(-num_reg) : DVD_W'(num_reg);
    assign dvd_cov = {4'b0, swp_reg, 16'b0} + {21'b0, sw_reg[SW_W-1:1]};
    assign dvd_val = nmag + {21'b0, sw_reg[SW_W-1:1]};

    adp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_val ? dvd_val : dvd_cov),
        .divisor  (sw_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg     <= in_px;
            py_reg     <= in_py;
            old_reg    <= in_old;
            bypass_reg <= (32'(in_px) >= 32'(IMAGE_SIZE)) || (32'(in_py) >= 32'(IMAGE_SIZE))
                          || !(fill_on || (draw_on && cfg.pen_half_width != '0));
        end
        if (cmd.setup) begin
            n_reg    <= n_c;
            m_reg    <= {2'b0, m_sat};
            dx_reg   <= -$signed({2'b0, m_sat});
            dy_reg   <= -$signed({2'b0, m_sat});
            bx_reg   <= $signed({3'b0, tx, 8'b0}) - cpx;
            by_reg   <= $signed({3'b0, ty, 8'b0}) - cpy;
            r_reg    <= {5'b0, cfg.radius} * {19'b0, n_c, 1'b0};
            h_reg    <= pen_eff * {19'b0, n_c, 1'b0};
            sw_reg   <= '0;
            swp_reg  <= '0;
            swpv_reg <= '0;
        end
        if (cmd.radsq) begin
            irad_reg  <= (r_reg > h_reg) ? r_reg - h_reg : '0;
            orad_reg  <= {1'b0, r_reg} + {1'b0, h_reg};
            irad2_reg <= ((r_reg > h_reg) ? {24'b0, r_reg - h_reg} : 48'b0)
                         * ((r_reg > h_reg) ? {24'b0, r_reg - h_reg} : 48'b0);
            orad2_reg <= ({26'b0, r_reg} + {26'b0, h_reg}) * ({26'b0, r_reg} + {26'b0, h_reg});
            h2_reg    <= {24'b0, h_reg} * {24'b0, h_reg};
        end
        if (cmd.rot) begin
            ax_reg <= ax_c;
            ay_reg <= ay_c;
            w_reg  <= {6'b0, weight1(adx, n_reg)} * {6'b0, weight1(ady, n_reg)};
        end
        if (cmd.sq) begin
            qx_reg  <= {28'b0, selx} * {28'b0, selx};
            qy_reg  <= {28'b0, sely} * {28'b0, sely};
            ax2_reg <= ax_reg;
            ay2_reg <= ay_reg;
            w2_reg  <= w_reg;
        end
        if (cmd.acc) begin
            sw_reg <= sw_reg + {7'b0, w2_reg};
            if (take) begin
                swp_reg  <= swp_reg + {7'b0, w2_reg};
                swpv_reg <= swpv_reg + wink;
            end
            if (dy_reg == m_reg) begin
                dy_reg <= -m_reg;
                dx_reg <= dx_reg + 5'sd1;
            end else begin
                dy_reg <= dy_reg + 5'sd1;
            end
        end
        if (cmd.prep_val)
            num_reg <= {{3{prod[36]}}, prod} + {{2{swpv_reg[SV_W-1]}}, swpv_reg};
        if (cmd.store_cov)
            cov_reg <= quo[COV_W-1:0];
        if (cmd.store_val) begin
            if (num_reg[DVD_W-1]) newv_reg <= VAL_W'(-quo);
            else if (quo > QUO_W'(32767)) newv_reg <= 16'sd32767;
            else newv_reg <= VAL_W'(quo);
        end
        if (cmd.out_load) begin
            out_new_reg <= bypass_reg ? old_reg : newv_reg;
            out_cov_reg <= bypass_reg ? '0 : cov_reg;
        end
    end

    assign sts.bypass      = bypass_reg;
    assign sts.last_sample = last;
    assign sts.div_done    = div_done;
    assign new_value       = out_new_reg;
    assign coverage        = out_cov_reg;

endmodule

>>> hw/rtl/adp_ctrl.sv
// Controller: sequences setup, the subsample loop, both divisions and the output handoff.
// Depends on adp_pkg.
`timescale 1ns / 1ps
module adp_ctrl import adp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        mvalid_next = mvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                // no request is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = sts.bypass ? ST_FIN : ST_RADSQ;
            end
            ST_RADSQ: begin
                cmd.radsq  = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                cmd.rot    = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = sts.last_sample ? ST_COV_START : ST_ROT;
            end
            ST_COV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_COV_WAIT;
            end
            ST_COV_WAIT: begin
                if (sts.div_done) begin
                    cmd.store_cov = 1'b1;
                    state_next    = ST_VAL_PREP;
                end
            end
            ST_VAL_PREP: begin
                cmd.prep_val = 1'b1;
                state_next   = ST_VAL_START;
            end
            ST_VAL_START: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_val = 1'b1;
                state_next      = ST_VAL_WAIT;
            end
            ST_VAL_WAIT: begin
                cmd.div_sel_val = 1'b1;
                if (sts.div_done) begin
                    cmd.store_val = 1'b1;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = mvalid_reg;

endmodule

>>> hw/rtl/antialiased_dot_painter.sv
// Antialiased dot painter, top level: configuration registers, controller and datapath.
// Depends on adp_pkg, adp_ctrl, adp_datapath.
`timescale 1ns / 1ps
// Paints one configured dot (round, square or 45-degree square, with fill and outline)
// over each pixel request and returns the blended value and the coverage. Requests are
// handled one at a time: each pixel is accepted, set up, run through the subsample loop (one
// shared shape-test and weighting path, three steps per sample) and two divisions, and
// handed to the output; a pixel outside the image or with nothing enabled skips from setup
// straight to the output handoff. A stalled output delays the handoff. A finished result
// waits in the output register while the next request is taken. The user must write the
// configuration only while idle; the block itself does not enforce it.
module antialiased_dot_painter import adp_pkg::*; #(
    parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // pixel_x[10:0], pixel_y[21:11], old_value[37:22]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // new_value[15:0], coverage[32:16]
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t      cfg_reg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic [VAL_W-1:0] new_value;
    logic [COV_W-1:0] coverage;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER_X: cfg_reg.center_x        <= cfg_wdata;
                REG_CENTER_Y: cfg_reg.center_y        <= cfg_wdata;
                REG_RADIUS:   cfg_reg.radius          <= cfg_wdata[18:0];
                REG_PEN:      cfg_reg.pen_half_width  <= cfg_wdata[18:0];
                REG_MODE:     cfg_reg.mode_flags      <= cfg_wdata[3:0];
                REG_FILL_INK: cfg_reg.fill_ink        <= cfg_wdata[15:0];
                REG_DRAW_INK: cfg_reg.draw_ink        <= cfg_wdata[15:0];
                REG_SUBS:     cfg_reg.subsample_level <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    adp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    adp_datapath #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .in_px     (s_tdata[10:0]),
        .in_py     (s_tdata[21:11]),
        .in_old    (s_tdata[37:22]),
        .sts       (sts),
        .new_value (new_value),
        .coverage  (coverage)
    );

    assign m_tdata = {7'b0, coverage, new_value};

endmodule

>>> sim/antialiased_dot_painter_tb.sv
// Self-checking testbench of the antialiased dot painter: directed table, directed shape cases, then random pixels.
// Expected pixels come from a behavioral painter below. Depends on adp_pkg and the RTL.
`timescale 1ns / 1ps
module antialiased_dot_painter_tb;
    import adp_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;    // pixel_x[10:0], pixel_y[21:11], old_value[37:22]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;    // new_value[15:0], coverage[32:16]
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    antialiased_dot_painter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    typedef struct packed {
        logic signed [15:0] value;
        logic [16:0]        cov;
    } pixel_out_t;

    typedef struct {
        logic [10:0]        px;
        logic [10:0]        py;
        logic signed [15:0] old;
        bit                 known;
        logic signed [15:0] value;
        logic [16:0]        cov;
    } pixel_row_t;

    cfg_t       dot;
    pixel_out_t pending_pixels[$];
    int         mismatches;
    int         send_idle_pct;
    int         recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("antialiased_dot_painter regression: fail");
        $finish;
    end

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint diag_mag(longint u);
        return ((absl(u) * 46341) + 32768) >>> 16;
    endfunction

    // 0 miss, 1 interior, 2 outline band
    function automatic int region_of(longint x, longint y, longint r, longint h, logic [1:0] shp);
        longint orad, irad, ax, ay;
        orad = r + h;
        irad = r > h ? r - h : 0;
        if (shp == SHAPE_ROUND) begin
            if (x*x + y*y < irad*irad) return 1;
            if (x*x + y*y < orad*orad) return 2;
            return 0;
        end
        if (shp == SHAPE_SQUARE) begin
            ax = absl(x);
            ay = absl(y);
        end else begin
            ax = diag_mag(x + y);
            ay = diag_mag(y - x);
        end
        if (ax < irad && ay < irad) return 1;
        if (ax > orad || ay > orad) return 0;
        if (ax < r || ay < r) return 2;
        ax -= r;
        ay -= r;
        if (ax*ax + ay*ay < h*h) return 2;
        return 0;
    endfunction

    function automatic longint tap_weight(longint a, longint n);
        if (2*a < n) return n*n - 2*a*a;
        return 2*(n-a)*(n-a);
    endfunction

    function automatic pixel_out_t paint_pixel(logic [10:0] px, logic [10:0] py,
                                               logic signed [15:0] old);
        pixel_out_t o;
        bit fill_on, draw_on;
        longint pen, n, m, r, h, bx, by, sw, swp, swpv, wx, w, num, q;
        int k;
        fill_on = dot.mode_flags[2];
        draw_on = dot.mode_flags[3];
        pen = draw_on ? longint'(dot.pen_half_width) : 0;
        o.value = old;
        o.cov = '0;
        if (!fill_on && pen == 0) return o;
        m = longint'(dot.subsample_level);
        n = m + 1;
        r = longint'(dot.radius) * 2 * n;
        h = pen * 2 * n;
        bx = (2*longint'(px) + 1) * 256 * n - 2 * n * longint'(dot.center_x);
        by = (2*longint'(py) + 1) * 256 * n - 2 * n * longint'(dot.center_y);
        sw = 0; swp = 0; swpv = 0;
        for (longint dx = -m; dx <= m; dx++) begin
            wx = tap_weight(absl(dx), n);
            for (longint dy = -m; dy <= m; dy++) begin
                w = wx * tap_weight(absl(dy), n);
                k = region_of(bx + 512*dx, by + 512*dy, r, h, dot.mode_flags[1:0]);
                if (k == 1 && fill_on) begin
                    swp += w; swpv += w * longint'(dot.fill_ink);
                end else if (k == 2 && draw_on) begin
                    swp += w; swpv += w * longint'(dot.draw_ink);
                end
                sw += w;
            end
        end
        o.cov = 17'((swp * 65536 + sw / 2) / sw);
        num = (sw - swp) * longint'(old) + swpv;
        q = num >= 0 ? (num + sw/2) / sw : -((-num + sw/2) / sw);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        o.value = 16'(q);
        return o;
    endfunction

    // leaves the write enable high; set_dot drops it after the last register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_CENTER_X: dot.center_x = val;
            REG_CENTER_Y: dot.center_y = val;
            REG_RADIUS:   dot.radius = val[18:0];
            REG_PEN:      dot.pen_half_width = val[18:0];
            REG_MODE:     dot.mode_flags = val[3:0];
            REG_FILL_INK: dot.fill_ink = val[15:0];
            REG_DRAW_INK: dot.draw_ink = val[15:0];
            REG_SUBS:     dot.subsample_level = val[2:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
    endtask

    // valid stays high after a request; it drops only for idle gaps and in wait_idle
    task automatic send_pixel(logic [10:0] px, logic [10:0] py, logic signed [15:0] old);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, old, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels.push_back(paint_pixel(px, py, old));
    endtask

    task automatic set_dot(logic [19:0] cx, logic [19:0] cy, logic [18:0] rad, logic [18:0] pen,
                           logic [3:0] mode, logic [15:0] fi, logic [15:0] di, logic [2:0] lvl);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS, {1'b0, rad});
        write_reg(REG_PEN, {1'b0, pen});
        write_reg(REG_MODE, {16'd0, mode});
        write_reg(REG_FILL_INK, {4'd0, fi});
        write_reg(REG_DRAW_INK, {4'd0, di});
        write_reg(REG_SUBS, {17'd0, lvl});
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: stall at random, check each result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_tdata);
                end else begin
                    pixel_out_t want;
                    want = pending_pixels.pop_front();
                    if (m_tdata[15:0] !== want.value || m_tdata[32:16] !== want.cov) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: value exp %0d got %0d, cov exp %0d got %0d",
                                     want.value, $signed(m_tdata[15:0]), want.cov,
                                     m_tdata[32:16]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    pixel_row_t dir_rows[] = '{
        // reset config: nothing enabled, pass-through
        '{11'd0,    11'd0,    16'sh8000, 1'b1, 16'sh8000, 17'd0},
        '{11'd2047, 11'd2047, 16'sh7FFF, 1'b1, 16'sh7FFF, 17'd0},
        '{11'd5,    11'd9,    16'sd123,  1'b1, 16'sd123,  17'd0}
    };

    task automatic random_dot(bit extreme);
        logic [3:0] mode;
        mode = 4'($urandom_range(15));
        if (extreme)
            set_dot(20'($urandom), 20'($urandom), 19'($urandom), 19'($urandom), mode,
                    16'($urandom), 16'($urandom), 3'($urandom));
        else
            set_dot({9'd0, 11'($urandom_range(40))} << 8 | 20'($urandom_range(255)),
                    {9'd0, 11'($urandom_range(40))} << 8 | 20'($urandom_range(255)),
                    19'($urandom_range(12*256)), 19'($urandom_range(4*256)),
                    mode, 16'($urandom), 16'($urandom), 3'($urandom_range(3)));
    endtask

    initial begin
        pixel_out_t want;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        dot = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].old);
            if (dir_rows[i].known) begin
                want = pending_pixels.pop_back();
                want.value = dir_rows[i].value;
                want.cov = dir_rows[i].cov;
                pending_pixels.push_back(want);
            end
        end
        wait_idle();

        // each shape with fill and outline both on, extremes of inks and levels
        for (int shp = 0; shp < 4; shp++) begin
            set_dot(20'd10 << 8, 20'd10 << 8, 19'd5 << 8, 19'd1 << 8, 4'(12 + shp),
                    16'h7FFF, 16'h8000, shp == 3 ? 3'd7 : 3'(shp));
            send_pixel(11'd10, 11'd10, 16'sh8000);
            send_pixel(11'd14, 11'd10, 16'sh7FFF);
            send_pixel(11'd15, 11'd15, 16'sd0);
            send_pixel(11'd2047, 11'd0, 16'sd77);
            wait_idle();
        end
        set_dot(20'h80000, 20'h7FFFF, 19'h7FFFF, 19'h7FFFF, 4'b1000, 16'h8000, 16'h7FFF, 3'd0);
        send_pixel(11'd0, 11'd2047, 16'sh7FFF);
        wait_idle();
        set_dot(20'd3 << 8, 20'd3 << 8, 19'd2 << 8, 19'd0, 4'b1000, 16'h1234, 16'h4321, 3'd1);
        send_pixel(11'd3, 11'd3, 16'sd500);     // draw on but pen zero: untouched
        wait_idle();

        for (int ph = 0; ph < 20; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            random_dot(ph % 5 == 4);
            for (int i = 0; i < 96; i++) begin
                if ($urandom_range(9) == 0)
                    send_pixel(11'($urandom), 11'($urandom), 16'($urandom));
                else
                    send_pixel(11'(dot.center_x[19:8] + $urandom_range(30) - 15),
                               11'(dot.center_y[19:8] + $urandom_range(30) - 15),
                               16'($urandom));
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("antialiased_dot_painter regression: pass");
        else
            $display("antialiased_dot_painter regression: fail");
        $finish;
    end
endmodule
